### src/wepms_pkg.sv
// Shared types and constants of the wrapped-encoder motor position controller.
`default_nettype none

package wepms_pkg;

	localparam int POS_W       = 12;
	localparam int GAIN_W      = 16;
	localparam int DUTY_W      = 17;
	localparam int DIGIT_W     = 4;
	localparam int DIGITS      = GAIN_W / DIGIT_W;
	localparam int CNT_W       = $clog2(DIGITS);
	localparam int INTEG_W     = 40;
	localparam int CMP_W       = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 17;
	localparam int MIN_ERROR   = 5;
	localparam int Q16_SHIFT   = 16;
	localparam int PWM_C_W     = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	localparam logic [DUTY_W-1:0] Q16_FULL = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_INTEG,
		S_DRIVE,
		S_MAG,
		S_SCALE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

endpackage

`default_nettype wire

### src/wepms_digit_mul.sv
// Digit-serial signed by unsigned multiplier, four gain bits per cycle while step is high, most significant first.
`default_nettype none

module wepms_digit_mul #(
	parameter int MCAND_W = 14
) (
	input  wire logic                                          clk,
	input  wire wepms_pkg::mul_ctl_t                           ctl,
	input  wire logic signed [MCAND_W-1:0]                     mcand,
	input  wire logic        [wepms_pkg::GAIN_W-1:0]           mplr,
	output logic      signed [MCAND_W+wepms_pkg::GAIN_W-1:0]   product
);

	localparam int PROD_W = MCAND_W + wepms_pkg::GAIN_W;

	logic signed [MCAND_W-1:0]                   mcand_q;
	logic        [wepms_pkg::GAIN_W-1:0]         mplr_q;
	logic signed [PROD_W-1:0]                    acc_q;
	logic        [wepms_pkg::DIGIT_W-1:0]        digit;
	logic signed [MCAND_W+wepms_pkg::DIGIT_W:0]  partial;

	assign digit   = mplr_q[wepms_pkg::GAIN_W-1 -: wepms_pkg::DIGIT_W];
	assign partial = mcand_q * $signed({1'b0, digit});
	assign product = acc_q;

	// The accumulator always holds mcand times the gain digits consumed so far.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q <= mcand;
			mplr_q  <= mplr;
			acc_q   <= '0;
		end else if (ctl.step) begin
			mplr_q <= mplr_q << wepms_pkg::DIGIT_W;
			acc_q  <= (acc_q <<< wepms_pkg::DIGIT_W) + PROD_W'(partial);
		end
	end

endmodule

`default_nettype wire

### src/wrapped_encoder_pd_motor_step_core.sv
// An accepted input beat passes through PREP, the MUL digit steps, INTEG, DRIVE, MAG and SCALE;
// the MUL steps form the digit-serial gain products (16-bit gains taken 4 bits per cycle),
// then four narrow sum, saturate and scale steps follow. A new input is taken only back in IDLE.
// One item is in flight at a time; a finished result waits in the output register.
// Reset clears the position and integral state, loads the register defaults
// (integ_step 1, max_duty full scale, others 0) and empties the output register.
`default_nettype none

module wrapped_encoder_pd_motor_step_core #(
	parameter int COUNTS_PER_REV = 4096,
	parameter int PWM_MAX_COUNT  = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// [11:0] measured_position, [23:12] target_position, [24] drive_enabled, rest zero
	input  wire logic [wepms_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// [10:0] compare_value, [11] direction_forward, rest zero
	output logic      [wepms_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                                   cfg_we,
	input  wire logic [wepms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [wepms_pkg::CFG_W-1:0]            cfg_data
);

	localparam int POS_W   = wepms_pkg::POS_W;
	localparam int GAIN_W  = wepms_pkg::GAIN_W;
	localparam int DUTY_W  = wepms_pkg::DUTY_W;
	localparam int INTEG_W = wepms_pkg::INTEG_W;
	localparam int DIFF_W  = $clog2(COUNTS_PER_REV + (1 << POS_W)) + 1;
	localparam int PROD_W  = DIFF_W + GAIN_W;
	localparam int PD_W    = PROD_W + 1;
	localparam int SUM_W   = (PROD_W > INTEG_W ? PROD_W : INTEG_W) + 1;
	localparam int DRV_W   = (PD_W > INTEG_W ? PD_W : INTEG_W) + 1;
	localparam int SCL_W   = DUTY_W + wepms_pkg::PWM_C_W;
	localparam int PAD_W   = wepms_pkg::OUT_TDATA_W - wepms_pkg::CMP_W - 1;

	localparam logic signed [DIFF_W-1:0] REV_S  = DIFF_W'(COUNTS_PER_REV);
	localparam logic signed [DIFF_W-1:0] QTR_S  = DIFF_W'(COUNTS_PER_REV / 4);
	localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(COUNTS_PER_REV / 2);
	localparam logic signed [DIFF_W-1:0] TOPQ_S = DIFF_W'(COUNTS_PER_REV - COUNTS_PER_REV / 4);
	localparam logic signed [DIFF_W-1:0] MINE_S = DIFF_W'(wepms_pkg::MIN_ERROR);
	localparam logic [wepms_pkg::PWM_C_W-1:0] PWM_C = wepms_pkg::PWM_C_W'(PWM_MAX_COUNT);

	wepms_pkg::state_t state_q, state_d;
	wepms_pkg::mul_ctl_t mul_ctl;

	logic [GAIN_W-1:0] prop_gain_q, deriv_gain_q, integ_step_q;
	logic [DUTY_W-1:0] max_duty_q, min_duty_q;

	logic        [POS_W-1:0]   last_pos_q, now_q, goal_q;
	logic                      en_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic                      cond_q;
	logic [wepms_pkg::CNT_W-1:0] cnt_q;
	logic signed [PD_W-1:0]    pd_q;
	logic signed [DRV_W-1:0]   drive_q;
	logic        [DUTY_W-1:0]  mag_q;
	logic                      neg_q;
	logic [wepms_pkg::CMP_W-1:0] cmp_q;
	logic                      fwd_q;
	logic                      out_valid_q;
	logic                      out_load;

	logic signed [DIFF_W-1:0] now_s, before_s, goal_s, diff_s, speed_s, err_s, abs_err_s;
	logic                     cross_up, cross_down;
	logic signed [PROD_W-1:0] p_prod, d_prod, i_prod;
	logic signed [SUM_W-1:0]  isum;
	logic signed [INTEG_W-1:0] isat;
	logic                     isum_ovf;
	logic        [DRV_W-1:0]  drive_abs;
	logic        [DUTY_W-1:0] cap, clamped;
	logic        [SCL_W-1:0]  scaled;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			deriv_gain_q <= '0;
			integ_step_q <= GAIN_W'(1);
			max_duty_q   <= wepms_pkg::Q16_FULL;
			min_duty_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wepms_pkg::CFG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				wepms_pkg::CFG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
				wepms_pkg::CFG_INTEG_STEP: integ_step_q <= cfg_data[GAIN_W-1:0];
				wepms_pkg::CFG_MAX_DUTY:   max_duty_q   <= cfg_data[DUTY_W-1:0];
				wepms_pkg::CFG_MIN_DUTY:   min_duty_q   <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Wrap-corrected speed and shortest signed error.
	always_comb begin
		now_s      = $signed(DIFF_W'(now_q));
		before_s   = $signed(DIFF_W'(last_pos_q));
		goal_s     = $signed(DIFF_W'(goal_q));
		cross_up   = (before_s > TOPQ_S) && (now_s < QTR_S);
		cross_down = (now_s > TOPQ_S) && (before_s < QTR_S);
		if (cross_up)
			speed_s = REV_S - before_s + now_s;
		else if (cross_down)
			speed_s = now_s - before_s - REV_S;
		else
			speed_s = now_s - before_s;
		diff_s = goal_s - now_s;
		if (diff_s > HALF_S)
			err_s = diff_s - REV_S;
		else if (diff_s < -HALF_S)
			err_s = diff_s + REV_S;
		else
			err_s = diff_s;
		abs_err_s = (err_s < 0) ? -err_s : err_s;
	end

	wepms_digit_mul #(.MCAND_W(DIFF_W)) u_prop_mul (
		.clk(clk), .ctl(mul_ctl), .mcand(err_s), .mplr(prop_gain_q), .product(p_prod)
	);

	wepms_digit_mul #(.MCAND_W(DIFF_W)) u_deriv_mul (
		.clk(clk), .ctl(mul_ctl), .mcand(speed_s), .mplr(deriv_gain_q), .product(d_prod)
	);

	wepms_digit_mul #(.MCAND_W(DIFF_W)) u_integ_mul (
		.clk(clk), .ctl(mul_ctl), .mcand(err_s), .mplr(integ_step_q), .product(i_prod)
	);

	// Integral saturation and output scaling.
	always_comb begin
		isum     = SUM_W'(integral_q) + SUM_W'(i_prod);
		isum_ovf = !((&isum[SUM_W-1:INTEG_W-1]) || !(|isum[SUM_W-1:INTEG_W-1]));
		if (isum_ovf)
			isat = isum[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			isat = isum[INTEG_W-1:0];
		drive_abs = (drive_q < 0) ? DRV_W'(-drive_q) : DRV_W'(drive_q);
		cap       = (max_duty_q > wepms_pkg::Q16_FULL) ? wepms_pkg::Q16_FULL : max_duty_q;
		clamped   = (drive_abs > DRV_W'(cap)) ? cap : drive_abs[DUTY_W-1:0];
		scaled    = SCL_W'(mag_q) * SCL_W'(PWM_C);
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			integral_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (state_q == wepms_pkg::S_PREP)
				last_pos_q <= now_q;
			if (state_q == wepms_pkg::S_INTEG)
				integral_q <= cond_q ? isat : '0;
			if (state_q == wepms_pkg::S_MUL)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			now_q  <= s_axis_tdata[POS_W-1:0];
			goal_q <= s_axis_tdata[2*POS_W-1:POS_W];
			en_q   <= s_axis_tdata[2*POS_W];
		end
		if (state_q == wepms_pkg::S_PREP)
			cond_q <= (abs_err_s > MINE_S) && (speed_s == '0);
		if (state_q == wepms_pkg::S_INTEG)
			pd_q <= PD_W'(p_prod) - PD_W'(d_prod);
		// The integral register already holds this tick's updated value here.
		if (state_q == wepms_pkg::S_DRIVE)
			drive_q <= en_q ? DRV_W'(pd_q) + DRV_W'(integral_q) : '0;
		if (state_q == wepms_pkg::S_MAG) begin
			mag_q <= (clamped > min_duty_q) ? clamped : '0;
			neg_q <= drive_q < 0;
		end
		if (out_load) begin
			cmp_q <= scaled[wepms_pkg::Q16_SHIFT +: wepms_pkg::CMP_W];
			fwd_q <= !neg_q;
		end
	end

	// Output register: holds a result beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wepms_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wepms_pkg::S_IDLE:  if (s_axis_tvalid) state_d = wepms_pkg::S_PREP;
			wepms_pkg::S_PREP:  state_d = wepms_pkg::S_MUL;
			wepms_pkg::S_MUL: begin
				if (cnt_q == wepms_pkg::CNT_W'(wepms_pkg::DIGITS - 1))
					state_d = wepms_pkg::S_INTEG;
			end
			wepms_pkg::S_INTEG: state_d = wepms_pkg::S_DRIVE;
			wepms_pkg::S_DRIVE: state_d = wepms_pkg::S_MAG;
			wepms_pkg::S_MAG:   state_d = wepms_pkg::S_SCALE;
			wepms_pkg::S_SCALE: if (!out_valid_q || m_axis_tready) state_d = wepms_pkg::S_IDLE;
			default:            state_d = wepms_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mul_ctl       = '0;
		out_load      = 1'b0;
		unique case (state_q)
			wepms_pkg::S_IDLE:  s_axis_tready = 1'b1;
			wepms_pkg::S_PREP:  mul_ctl.load  = 1'b1;
			wepms_pkg::S_MUL:   mul_ctl.step  = 1'b1;
			wepms_pkg::S_SCALE: out_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, fwd_q, cmp_q};

endmodule

`default_nettype wire

### src/wepms_checker.sv
// Port-level checks of the motor position controller, bound to its top level.
`default_nettype none

module wepms_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_axis_tvalid,
	input wire logic                                s_axis_tready,
	input wire logic                                m_axis_tvalid,
	input wire logic                                m_axis_tready,
	input wire logic [wepms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int PAD_LO = wepms_pkg::CMP_W + 1;

	// A result beat that is stalled stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed or vanished");

	// Only one item is worked on at a time: input stays blocked while an accepted item is in PREP and its first MUL step.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input accepted while an item was in progress");

	// A result never appears straight after an input beat is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result beat appeared one cycle after accept");

	// Padding bits above the direction flag stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[wepms_pkg::OUT_TDATA_W-1:PAD_LO] == '0)
		else $error("result padding bits not zero");

endmodule

bind wrapped_encoder_pd_motor_step_core wepms_checker u_wepms_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

### tb/tb_wrapped_encoder_pd_motor_step_core.sv
// Self-checking testbench of the wrapped-encoder motor position controller core.
module tb_wrapped_encoder_pd_motor_step_core;
	timeunit 1ns;
	timeprecision 1ps;
	import wepms_pkg::*;

	localparam int REV          = 4096;
	localparam int PWM_COUNT    = 1024;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int SAT_TICKS    = 10;
	localparam int RAND_TICKS   = 90;
	localparam int REPORT_LIMIT = 40;
	localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
	localparam longint INTEG_LO = -INTEG_HI - 1;
	// Index with no register behind it; writes there must leave everything alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

	typedef struct packed {
		logic                 enable;
		logic [POS_W-1:0]     target;
		logic [POS_W-1:0]     measured;
	} tick_t;

	typedef struct packed {
		logic                 fwd;
		logic [CMP_W-1:0]     cmp;
	} pwm_out_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_style_t;
	typedef enum logic [2:0] {
		SET_MID, SET_FULL, SET_ZERO, SET_EDGE, SET_FLOOR, SET_ANY, SET_DAMP
	} setting_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// Controller copy: registers at their reset values, state cleared.
	logic [GAIN_W-1:0]      prop_k = '0;
	logic [GAIN_W-1:0]      deriv_k = '0;
	logic [GAIN_W-1:0]      step_k = 16'd1;
	logic [DUTY_W-1:0]      duty_cap = Q16_FULL;
	logic [DUTY_W-1:0]      duty_floor = '0;
	logic [POS_W-1:0]       last_pos = '0;
	longint                 integ = 0;

	tick_t                  pending_ticks[$];
	pwm_out_t               duty_expected[$];
	int                     ticks_queued = 0;
	int                     ticks_taken = 0;
	int                     results_checked = 0;
	int                     errors = 0;
	int                     settings_used = 0;
	int                     quiet_cycles = 0;
	logic                   beat_taken = 1'b0;
	logic                   steady = 1'b0;
	int                     burst_left = 0;
	int                     gap_left = 0;
	int                     hold_asked = 0;
	int                     hold_given = 0;
	int                     hold_left = 0;
	int                     mode_left = 0;
	int                     rx_tick = 0;
	rx_style_t              rx_style = RX_OPEN;

	// Fixed opening ticks, each {enable, target, measured}: zero error, both half-turn
	// distances, wrap in both directions, quarter boundaries and the integral threshold.
	tick_t opening [20] = '{
		{1'b1, 12'd0,    12'd0},    {1'b1, 12'd2048, 12'd0},    {1'b1, 12'd2049, 12'd0},
		{1'b1, 12'd0,    12'd2048}, {1'b1, 12'd0,    12'd2049}, {1'b1, 12'd4095, 12'd4095},
		{1'b1, 12'd4095, 12'd0},    {1'b1, 12'd0,    12'd4095}, {1'b1, 12'd3000, 12'd3073},
		{1'b1, 12'd1000, 12'd1023}, {1'b1, 12'd3100, 12'd3072}, {1'b1, 12'd1029, 12'd1024},
		{1'b1, 12'd1029, 12'd1024}, {1'b1, 12'd1030, 12'd1024}, {1'b0, 12'd1030, 12'd1024},
		{1'b1, 12'd1030, 12'd1024}, {1'b1, 12'd1018, 12'd1024}, {1'b1, 12'd1018, 12'd1024},
		{1'b1, 12'd1024, 12'd1024}, {1'b0, 12'd4095, 12'd0}
	};

	setting_t phase_plan [8] = '{
		SET_MID, SET_FULL, SET_ZERO, SET_EDGE, SET_FLOOR, SET_ANY, SET_MID, SET_DAMP
	};

	wrapped_encoder_pd_motor_step_core #(
		.COUNTS_PER_REV (REV),
		.PWM_MAX_COUNT  (PWM_COUNT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// One control tick: update speed, error and integral, then work out duty and direction.
	task automatic predict_duty(input tick_t t);
		longint here, goal, prior, speed, err, grow, drive, mag, cap, scaled;
		pwm_out_t r;
		here = longint'(t.measured);
		goal = longint'(t.target);
		prior = longint'(last_pos);
		last_pos = t.measured;
		if (prior > REV - REV / 4 && here < REV / 4)
			speed = (REV - prior) + here;
		else if (here > REV - REV / 4 && prior < REV / 4)
			speed = here - (prior + REV);
		else
			speed = here - prior;
		err = goal - here;
		if (err > REV / 2)
			err = err - REV;
		else if (err < -(REV / 2))
			err = err + REV;
		if ((err > MIN_ERROR || err < -MIN_ERROR) && speed == 0) begin
			grow = integ + longint'(step_k) * err;
			if (grow > INTEG_HI)
				grow = INTEG_HI;
			else if (grow < INTEG_LO)
				grow = INTEG_LO;
			integ = grow;
		end else begin
			integ = 0;
		end
		if (t.enable)
			drive = longint'(prop_k) * err - longint'(deriv_k) * speed + integ;
		else
			drive = 0;
		mag = drive < 0 ? -drive : drive;
		cap = duty_cap > Q16_FULL ? longint'(Q16_FULL) : longint'(duty_cap);
		if (mag > cap)
			mag = cap;
		if (!(mag > longint'(duty_floor)))
			mag = 0;
		scaled = (mag * PWM_COUNT) >> Q16_SHIFT;
		r.cmp = scaled[CMP_W-1:0];
		r.fwd = drive >= 0;
		duty_expected.push_back(r);
	endtask

	task automatic queue_tick(input tick_t t);
		pending_ticks.push_back(t);
		ticks_queued++;
	endtask

	// Mostly runs that rest on one count so the integral builds up, runs that hop
	// across the wrap point, and some plain noise.
	task automatic queue_random(input int n);
		int left, run, kind;
		logic [POS_W-1:0] p, q;
		logic en;
		tick_t t;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			run = $urandom_range(2, 12);
			if (run > left)
				run = left;
			en = $urandom_range(0, 7) != 0;
			p = 12'($urandom);
			if (kind < 5) begin
				if ($urandom_range(0, 1))
					q = p + 12'($urandom_range(0, 16)) - 12'd8;
				else
					q = 12'($urandom);
				for (int i = 0; i < run; i++)
					queue_tick({en, q, p});
			end else if (kind < 8) begin
				for (int i = 0; i < run; i++) begin
					p = (i % 2) ? 12'($urandom_range(0, 1100)) : 12'($urandom_range(3000, 4095));
					queue_tick({en, 12'($urandom), p});
				end
			end else begin
				for (int i = 0; i < run; i++) begin
					t = 25'($urandom);
					queue_tick(t);
				end
			end
			left -= run;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_PROP_GAIN:  prop_k = val[GAIN_W-1:0];
			CFG_DERIV_GAIN: deriv_k = val[GAIN_W-1:0];
			CFG_INTEG_STEP: step_k = val[GAIN_W-1:0];
			CFG_MAX_DUTY:   duty_cap = val;
			CFG_MIN_DUTY:   duty_floor = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] d,
			input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] mx,
			input logic [CFG_W-1:0] mn, input logic spare);
		write_reg(CFG_PROP_GAIN, p);
		write_reg(CFG_DERIV_GAIN, d);
		write_reg(CFG_INTEG_STEP, s);
		write_reg(CFG_MAX_DUTY, mx);
		write_reg(CFG_MIN_DUTY, mn);
		if (spare)
			write_reg(CFG_SPARE, 17'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Settles once every queued tick has been taken and answered, plus the core's latency.
	task automatic wait_idle();
		while (ticks_taken != ticks_queued || duty_expected.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	always @(negedge clk) begin : drive_ticks
		logic  offer;
		tick_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && !beat_taken) begin
				offer = 1'b1;
			end else begin
				offer = 1'b0;
				if (gap_left > 0 && !steady) begin
					gap_left--;
				end else if (pending_ticks.size() > 0) begin
					offer = 1'b1;
					nxt = pending_ticks.pop_front();
					s_axis_tdata <= IN_TDATA_W'(nxt);
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 11);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
					end
				end
			end
			beat_taken = 1'b0;
			s_axis_tvalid <= offer;
		end
	end

	always @(negedge clk) begin : drive_ready
		logic rdy;
		if (hold_asked != hold_given) begin
			hold_given = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 160);
		end else begin
			mode_left--;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (steady) begin
			rdy = 1'b1;
		end else begin
			case (rx_style)
				RX_OPEN:   rdy = 1'b1;
				RX_COIN:   rdy = 1'($urandom_range(0, 1));
				RX_EVERY4: rdy = (rx_tick % 4) == 0;
				default:   rdy = $urandom_range(0, 11) == 0;
			endcase
		end
		m_axis_tready <= rdy;
	end

	always @(posedge clk) begin : watch_beats
		pwm_out_t got, want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_duty(tick_t'(s_axis_tdata[24:0]));
				ticks_taken++;
				beat_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[CMP_W:0];
				results_checked++;
				if (duty_expected.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: unexpected result beat, compare %0d fwd %0b",
							$time, got.cmp, got.fwd);
				end else begin
					want = duty_expected.pop_front();
					if (got.cmp !== want.cmp || got.fwd !== want.fwd) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("%0t: expected compare %0d fwd %0b, got compare %0d fwd %0b",
								$time, want.cmp, want.fwd, got.cmp, got.fwd);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : run_test
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A first stretch under the reset register values.
		queue_random(40);
		wait_idle();

		load_settings(17'd300, 17'd200, 17'd5000, 17'd65536, 17'd0, 1'b0);
		foreach (opening[i])
			queue_tick(opening[i]);
		wait_idle();

		foreach (phase_plan[k]) begin
			case (phase_plan[k])
				SET_MID:   load_settings(17'($urandom_range(1, 64)), 17'($urandom_range(1, 64)),
						17'($urandom_range(1, 4000)), 17'd65536,
						17'($urandom_range(0, 2000)), 1'b0);
				SET_FULL:  load_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd0, 1'b0);
				SET_ZERO:  load_settings(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b0);
				SET_EDGE:  load_settings(17'($urandom_range(1, 16)), 17'd0, 17'd0,
						17'($urandom_range(64, 1500)), 17'($urandom_range(0, 80)), 1'b0);
				SET_FLOOR: load_settings(17'($urandom_range(1, 65535)),
						17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65535)),
						17'd65536, 17'd65536, 1'b0);
				SET_ANY:   load_settings(17'($urandom), 17'($urandom), 17'($urandom),
						17'($urandom), 17'($urandom), 1'b1);
				default:   load_settings(17'd0, 17'($urandom_range(1, 200)),
						17'($urandom_range(0, 65535)), 17'd65536,
						17'($urandom_range(0, 300)), 1'b0);
			endcase
			// The first phase starts with the output held off so that the input backs up.
			if (k == 0)
				hold_asked++;
			queue_random(RAND_TICKS);
			wait_idle();
		end

		// Integral built up positive, swung negative and back again, resting on one
		// count with the largest step and error, items sent back to back.
		steady = 1'b1;
		load_settings(17'd0, 17'd0, 17'd65535, 17'd65536, 17'd0, 1'b0);
		for (int i = 0; i < SAT_TICKS; i++)
			queue_tick({1'b1, 12'd4095, 12'd2048});
		for (int i = 0; i < 2 * SAT_TICKS; i++)
			queue_tick({1'b1, 12'd0, 12'd2048});
		for (int i = 0; i < SAT_TICKS; i++)
			queue_tick({1'b1, 12'd4095, 12'd2048});
		wait_idle();
		steady = 1'b0;
		repeat (20) @(negedge clk);

		if (duty_expected.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, duty_expected.size());
		end
		$display("Ran %0d control ticks over %0d register settings, %0d results checked,",
			ticks_taken, settings_used, results_checked);
		$display("with a %0d-cycle output hold-off and a steady integral build-up and swing.",
			HOLD_CYCLES);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
